>>> design/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants
// Widths, region codes and the sideband record carried down the pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int CW = 24;          // coordinate width
	localparam int DW = CW + 1;      // coordinate difference width
	localparam int PW = 2 * DW;      // product / squared length width
	localparam int OW = 50;          // result width
	localparam int NW = 2 * PW;      // squared cross product width
	localparam int HW = PW / 2;      // partial product split point

	localparam logic [1:0] REG_FOOT  = 2'd0;
	localparam logic [1:0] REG_START = 2'd1;
	localparam logic [1:0] REG_END   = 2'd2;

	typedef struct packed {
		logic [OW-1:0] dist_ep;     // endpoint distance (start or end)
		logic [1:0]    region;
		logic          degen;
	} side_t;

endpackage

>>> design/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front: geometry front end
// Differences, products, dot and cross sums, region classification.
// ----------------------------------------------------------------------------
module psd_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_vld,
	input  logic signed [psd_pkg::CW-1:0]   start_x,
	input  logic signed [psd_pkg::CW-1:0]   start_y,
	input  logic signed [psd_pkg::CW-1:0]   end_x,
	input  logic signed [psd_pkg::CW-1:0]   end_y,
	input  logic signed [psd_pkg::CW-1:0]   query_x,
	input  logic signed [psd_pkg::CW-1:0]   query_y,
	output logic                            out_vld,
	output psd_pkg::side_t                  out_side,
	output logic [psd_pkg::PW-1:0]          out_cross,
	output logic [psd_pkg::PW-1:0]          out_len2
);
	import psd_pkg::*;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [DW-1:0] dx_s1, dy_s1, px_s1, py_s1, ux_s1, uy_s1;
	logic signed [PW-1:0] dxdx_s2, dydy_s2, pxdx_s2, pydy_s2, pxdy_s2, pydx_s2;
	logic signed [PW-1:0] pxpx_s2, pypy_s2, uxux_s2, uyuy_s2;
	logic signed [PW:0]   len2_s3, dot_s3, cross_s3, dst_s3, den_s3;
	side_t                side_s4;
	logic [PW-1:0]        cross_s4, len2_s4;
	logic                 degen, nonpos, past_end;
	logic [1:0]           region;
	logic signed [PW:0]   abs_cross;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// s1: coordinate differences
	always_ff @(posedge clk) begin
		dx_s1 <= {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
		dy_s1 <= {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
		px_s1 <= {query_x[CW-1], query_x} - {start_x[CW-1], start_x};
		py_s1 <= {query_y[CW-1], query_y} - {start_y[CW-1], start_y};
		ux_s1 <= {query_x[CW-1], query_x} - {end_x[CW-1], end_x};
		uy_s1 <= {query_y[CW-1], query_y} - {end_y[CW-1], end_y};
	end

	// s2: products
	always_ff @(posedge clk) begin
		dxdx_s2 <= dx_s1 * dx_s1;
		dydy_s2 <= dy_s1 * dy_s1;
		pxdx_s2 <= px_s1 * dx_s1;
		pydy_s2 <= py_s1 * dy_s1;
		pxdy_s2 <= px_s1 * dy_s1;
		pydx_s2 <= py_s1 * dx_s1;
		pxpx_s2 <= px_s1 * px_s1;
		pypy_s2 <= py_s1 * py_s1;
		uxux_s2 <= ux_s1 * ux_s1;
		uyuy_s2 <= uy_s1 * uy_s1;
	end

	// s3: sums
	always_ff @(posedge clk) begin
		len2_s3  <= {dxdx_s2[PW-1], dxdx_s2} + {dydy_s2[PW-1], dydy_s2};
		dot_s3   <= {pxdx_s2[PW-1], pxdx_s2} + {pydy_s2[PW-1], pydy_s2};
		cross_s3 <= {pxdy_s2[PW-1], pxdy_s2} - {pydx_s2[PW-1], pydx_s2};
		dst_s3   <= {pxpx_s2[PW-1], pxpx_s2} + {pypy_s2[PW-1], pypy_s2};
		den_s3   <= {uxux_s2[PW-1], uxux_s2} + {uyuy_s2[PW-1], uyuy_s2};
	end

	// s4: classification
	always_comb begin
		degen     = (len2_s3 == '0);
		nonpos    = dot_s3[PW] || (dot_s3 == '0);
		past_end  = (dot_s3 >= len2_s3);
		abs_cross = cross_s3[PW] ? -cross_s3 : cross_s3;
		priority if (degen || nonpos) region = REG_START;
		else if (past_end)            region = REG_END;
		else                          region = REG_FOOT;
	end

	always_ff @(posedge clk) begin
		side_s4.degen   <= degen;
		side_s4.region  <= region;
		side_s4.dist_ep <= (region == REG_END) ? den_s3[OW-1:0] : dst_s3[OW-1:0];
		cross_s4        <= abs_cross[PW-1:0];
		len2_s4         <= len2_s3[PW-1:0];
	end

	assign out_vld   = vld_s4;
	assign out_side  = side_s4;
	assign out_cross = cross_s4;
	assign out_len2  = len2_s4;

endmodule

>>> design/psd_sqr.sv
// ----------------------------------------------------------------------------
// psd_sqr: cross product squarer
// Squares the magnitude of the cross product from four half-width products.
// ----------------------------------------------------------------------------
module psd_sqr (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  psd_pkg::side_t            in_side,
	input  logic [psd_pkg::PW-1:0]    in_cross,
	input  logic [psd_pkg::PW-1:0]    in_len2,
	output logic                      out_vld,
	output psd_pkg::side_t            out_side,
	output logic [psd_pkg::NW-1:0]    out_num,
	output logic [psd_pkg::PW-1:0]    out_len2
);
	import psd_pkg::*;

	logic               vld_s5, vld_s6;
	side_t              side_s5, side_s6;
	logic [PW-1:0]      len2_s5, len2_s6;
	logic [2*HW-1:0]    hh_s5, hl_s5, lh_s5, ll_s5;
	logic [NW-1:0]      num_s6;
	logic [HW-1:0]      hi, lo;

	assign hi = in_cross[PW-1:HW];
	assign lo = in_cross[HW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s5 <= in_vld;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		hh_s5   <= hi * hi;
		hl_s5   <= hi * lo;
		lh_s5   <= lo * hi;
		ll_s5   <= lo * lo;
		side_s5 <= in_side;
		len2_s5 <= in_len2;
	end

	always_ff @(posedge clk) begin
		num_s6  <= ({{(NW-2*HW){1'b0}}, hh_s5} << (2*HW))
		         + ({{(NW-2*HW){1'b0}}, hl_s5} << HW)
		         + ({{(NW-2*HW){1'b0}}, lh_s5} << HW)
		         +  {{(NW-2*HW){1'b0}}, ll_s5};
		side_s6 <= side_s5;
		len2_s6 <= len2_s5;
	end

	assign out_vld  = vld_s6;
	assign out_side = side_s6;
	assign out_num  = num_s6;
	assign out_len2 = len2_s6;

endmodule

>>> design/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div: pipelined restoring divider
// One quotient bit per stage, then round to nearest with ties up.
// ----------------------------------------------------------------------------
module psd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  psd_pkg::side_t            in_side,
	input  logic [psd_pkg::NW-1:0]    in_num,
	input  logic [psd_pkg::PW-1:0]    in_den,
	output logic                      out_vld,
	output psd_pkg::side_t            out_side,
	output logic [psd_pkg::OW-1:0]    out_quo
);
	import psd_pkg::*;

	localparam int NQ = PW;

	logic          vld_q  [0:NQ];
	side_t         side_q [0:NQ];
	logic [PW-1:0] rem_q  [0:NQ];
	logic [PW-1:0] low_q  [0:NQ];
	logic [PW-1:0] quo_q  [0:NQ];
	logic [PW-1:0] den_q  [0:NQ];

	logic          vld_r;
	side_t         side_r;
	logic [OW-1:0] quo_r;

	// stage 0 is the incoming request; upper half below the divisor unless the segment has zero length
	assign vld_q[0]  = in_vld;
	assign side_q[0] = in_side;
	assign rem_q[0]  = in_num[NW-1:PW];
	assign low_q[0]  = in_num[PW-1:0];
	assign quo_q[0]  = '0;
	assign den_q[0]  = in_den;

	for (genvar i = 0; i < NQ; i++) begin : g_stage
		logic [PW:0] trial;
		logic        take;

		assign trial = {rem_q[i], low_q[i][PW-1]};
		assign take  = (trial >= {1'b0, den_q[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else begin
				vld_q[i+1] <= vld_q[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[i+1]  <= take ? PW'(trial - {1'b0, den_q[i]}) : trial[PW-1:0];
			low_q[i+1]  <= {low_q[i][PW-2:0], 1'b0};
			quo_q[i+1]  <= {quo_q[i][PW-2:0], take};
			den_q[i+1]  <= den_q[i];
			side_q[i+1] <= side_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r <= 1'b0;
		end else begin
			vld_r <= vld_q[NQ];
		end
	end

	always_ff @(posedge clk) begin
		if ({rem_q[NQ], 1'b0} >= {1'b0, den_q[NQ]}) begin
			quo_r <= OW'(quo_q[NQ] + 1'b1);
		end else begin
			quo_r <= OW'(quo_q[NQ]);
		end
		side_r <= side_q[NQ];
	end

	assign out_vld  = vld_r;
	assign out_side = side_r;
	assign out_quo  = quo_r;

endmodule

>>> design/point_segment_distance_squared.sv
// ----------------------------------------------------------------------------
// point_segment_distance_squared: squared point to segment distance
// Fully pipelined; one request per clock, fixed latency.
// ----------------------------------------------------------------------------
// A request (segment start, segment end, query point; 24-bit signed fixed
// point) is taken on any clock edge with start high. busy never rises: the
// pipeline takes one request every cycle and the receiver cannot stall it.
// Each request yields exactly one result, shown for one cycle with
// result_valid high, in request order. Every request, interior or endpoint,
// passes through four geometry stages, two squaring stages, a divider that
// retires one quotient bit per stage over 50 stages, a rounding stage and
// the output register.
// distance_sqd is in units of 2^-40. nearest_region: 0 foot point inside the
// segment, 1 start (projection fraction zero or below, or zero-length
// segment), 2 end. degenerate flags a zero-length segment.
// ----------------------------------------------------------------------------
module point_segment_distance_squared (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [psd_pkg::CW-1:0]   start_x,
	input  logic signed [psd_pkg::CW-1:0]   start_y,
	input  logic signed [psd_pkg::CW-1:0]   end_x,
	input  logic signed [psd_pkg::CW-1:0]   end_y,
	input  logic signed [psd_pkg::CW-1:0]   query_x,
	input  logic signed [psd_pkg::CW-1:0]   query_y,
	output logic                            result_valid,
	output logic [psd_pkg::OW-1:0]          distance_sqd,
	output logic [1:0]                      nearest_region,
	output logic                            degenerate
);
	import psd_pkg::*;

	// front end: differences, products, sums, classification
	logic          fe_vld;
	side_t         fe_side;
	logic [PW-1:0] fe_cross, fe_len2;

	// squarer: cross^2 as the division numerator
	logic          sq_vld;
	side_t         sq_side;
	logic [NW-1:0] sq_num;
	logic [PW-1:0] sq_len2;

	// divider: interior distance cross^2 / len2
	logic          dv_vld;
	side_t         dv_side;
	logic [OW-1:0] dv_quo;

	logic          vld_q;
	logic [OW-1:0] dist_q;
	logic [1:0]    region_q;
	logic          degen_q;

	// never stalls
	assign busy = 1'b0;

	psd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.query_x   (query_x),
		.query_y   (query_y),
		.out_vld   (fe_vld),
		.out_side  (fe_side),
		.out_cross (fe_cross),
		.out_len2  (fe_len2)
	);

	psd_sqr u_sqr (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (fe_vld),
		.in_side  (fe_side),
		.in_cross (fe_cross),
		.in_len2  (fe_len2),
		.out_vld  (sq_vld),
		.out_side (sq_side),
		.out_num  (sq_num),
		.out_len2 (sq_len2)
	);

	// endpoint cases also run through; their quotient is simply ignored
	psd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld),
		.in_side  (sq_side),
		.in_num   (sq_num),
		.in_den   (sq_len2),
		.out_vld  (dv_vld),
		.out_side (dv_side),
		.out_quo  (dv_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= dv_vld;
		end
	end

	// result register: interior quotient or endpoint distance
	always_ff @(posedge clk) begin
		dist_q   <= (dv_side.region == REG_FOOT) ? dv_quo : dv_side.dist_ep;
		region_q <= dv_side.region;
		degen_q  <= dv_side.degen;
	end

	assign result_valid   = vld_q;
	assign distance_sqd   = dist_q;
	assign nearest_region = region_q;
	assign degenerate     = degen_q;

endmodule
